### design/sjcp_pkg.sv
// sjcp_pkg: widths, reset values, command codes and register indexes for the
// servo jog command positioner. No dependencies.
package sjcp_pkg;

  localparam int unsigned CmdW   = 8;
  localparam int unsigned WidthW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [WidthW-1:0]  width_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register indexes on the configuration channel
  localparam cfg_idx_t REG_DEFAULT_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_STEP_SIZE      = 2'd1;
  localparam cfg_idx_t REG_PULSE_OVERHEAD = 2'd2;

  // reset values
  localparam width_t DEFAULT_WIDTH_RST  = 16'd1500;
  localparam width_t STEP_SIZE_RST      = 16'd50;
  localparam width_t PULSE_OVERHEAD_RST = 16'd500;
  localparam width_t MIN_RST            = 16'd0;
  localparam width_t MAX_RST            = 16'hFFFF;

  // command bytes
  localparam cmd_t CMD_STEP_DOWN = 8'h2C;
  localparam cmd_t CMD_STEP_UP   = 8'h2E;
  localparam cmd_t CMD_CENTRE    = 8'h20;
  localparam cmd_t CMD_RESET     = 8'h0D;
  localparam cmd_t CMD_SET_MIN   = 8'h3C;
  localparam cmd_t CMD_SET_MAX   = 8'h3E;
  localparam cmd_t CMD_DIGIT_0   = 8'h30;
  localparam cmd_t CMD_DIGIT_9   = 8'h39;

  // digit placement: numerator up to 9 * 65535 + 4, divided by 9
  localparam int unsigned NumW      = 20;
  localparam int unsigned DigitW    = 4;
  localparam logic [DigitW-1:0] DIGIT_SPAN = 4'd9;
  localparam logic [NumW-1:0]   ROUND_ADD  = 20'd4;
  // ceil(2^23 / 9); exact for numerators below 2^21
  localparam int unsigned RecipShift = 23;
  localparam logic [NumW-1:0]   RECIP_NINE = 20'd932068;

endpackage

### design/sjcp_if.sv
// sjcp_if: valid/ready channels of the positioner: command in, result out and
// configuration writes. Depends on sjcp_pkg.
interface sjcp_in_if;
  logic               valid;
  logic               ready;
  sjcp_pkg::cmd_t     cmd_byte;
  modport source (output valid, output cmd_byte, input ready);
  modport sink   (input valid, input cmd_byte, output ready);
endinterface

interface sjcp_out_if;
  logic               valid;
  logic               ready;
  sjcp_pkg::width_t   pulse_width;
  sjcp_pkg::width_t   low_limit;
  sjcp_pkg::width_t   high_limit;
  sjcp_pkg::width_t   high_time;
  logic               cmd_status;
  modport source (output valid, output pulse_width, output low_limit, output high_limit,
                  output high_time, output cmd_status, input ready);
  modport sink   (input valid, input pulse_width, input low_limit, input high_limit,
                  input high_time, input cmd_status, output ready);
endinterface

interface sjcp_cfg_if;
  logic               valid;
  logic               ready;
  sjcp_pkg::cfg_idx_t index;
  sjcp_pkg::width_t   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/servo_jog_command_positioner.sv
// A command beat is registered in the command stage, its result in the result stage.
// Throughput: one command beat per cycle unless the output stalls; while a result
// beat waits on a stalled output, the command register takes a beat only if empty.
// Reset (rst_n low, synchronous): width 1500, limits 0 and 65535, registers to
// their defaults, both stages empty. Configuration writes are always taken.
module servo_jog_command_positioner (
  input  logic              clk,
  input  logic              rst_n,
  sjcp_in_if.sink           in_if,
  sjcp_out_if.source        out_if,
  sjcp_cfg_if.sink          cfg_if
);

  // configuration registers
  sjcp_pkg::width_t default_width_r;
  sjcp_pkg::width_t step_size_r;
  sjcp_pkg::width_t pulse_overhead_r;

  // command stage
  logic             in_valid_r;
  sjcp_pkg::cmd_t   cmd_r;

  // positioner state
  sjcp_pkg::width_t width_r, width_nxt;
  sjcp_pkg::width_t min_r, min_nxt;
  sjcp_pkg::width_t max_r, max_nxt;

  // result stage
  logic             out_valid_r;
  sjcp_pkg::width_t pulse_width_r;
  sjcp_pkg::width_t low_limit_r;
  sjcp_pkg::width_t high_limit_r;
  sjcp_pkg::width_t high_time_r, high_time_nxt;
  logic             cmd_status_r, cmd_status_nxt;

  logic             advance;
  logic             in_take;

  // datapath intermediates
  logic [sjcp_pkg::WidthW:0]         centre_sum;
  sjcp_pkg::width_t                  centre_q;
  logic [sjcp_pkg::DigitW-1:0]       digit;
  logic [sjcp_pkg::NumW-1:0]         digit_num;
  logic [2*sjcp_pkg::NumW-1:0]       digit_prod;
  sjcp_pkg::width_t                  digit_q;
  sjcp_pkg::width_t                  dn_w;
  sjcp_pkg::width_t                  up_w;
  logic                              is_digit;

  assign advance      = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || advance;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // centre with round-half-even
  assign centre_sum = {1'b0, min_r} + {1'b0, max_r};
  assign centre_q   = centre_sum[sjcp_pkg::WidthW:1] +
                      sjcp_pkg::width_t'(centre_sum[0] & centre_sum[1]);

  // digit placement: ((9-d)*min + d*max + 4) / 9 via reciprocal multiply
  assign digit      = cmd_r[sjcp_pkg::DigitW-1:0];
  assign is_digit   = (cmd_r >= sjcp_pkg::CMD_DIGIT_0) && (cmd_r <= sjcp_pkg::CMD_DIGIT_9);
  assign digit_num  = sjcp_pkg::NumW'(sjcp_pkg::DIGIT_SPAN - digit) * sjcp_pkg::NumW'(min_r)
                    + sjcp_pkg::NumW'(digit) * sjcp_pkg::NumW'(max_r)
                    + sjcp_pkg::ROUND_ADD;
  assign digit_prod = (2*sjcp_pkg::NumW)'(digit_num) * (2*sjcp_pkg::NumW)'(sjcp_pkg::RECIP_NINE);
  assign digit_q    = digit_prod[sjcp_pkg::RecipShift +: sjcp_pkg::WidthW];

  // step down only when above the step, then clamp to the lower limit
  always_comb begin
    dn_w = (width_r > step_size_r) ? width_r - step_size_r : width_r;
    if (dn_w < min_r) begin
      dn_w = min_r;
    end
  end

  // step up only when headroom exceeds the step, then clamp to the upper limit
  always_comb begin
    up_w = ((sjcp_pkg::MAX_RST - width_r) > step_size_r) ? width_r + step_size_r : width_r;
    if (up_w > max_r) begin
      up_w = max_r;
    end
  end

  always_comb begin
    width_nxt      = width_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    cmd_status_nxt = 1'b0;
    unique case (cmd_r)
      sjcp_pkg::CMD_STEP_DOWN: width_nxt = dn_w;
      sjcp_pkg::CMD_STEP_UP:   width_nxt = up_w;
      sjcp_pkg::CMD_CENTRE:    width_nxt = centre_q;
      sjcp_pkg::CMD_RESET: begin
        min_nxt   = sjcp_pkg::MIN_RST;
        max_nxt   = sjcp_pkg::MAX_RST;
        width_nxt = default_width_r;
      end
      sjcp_pkg::CMD_SET_MIN:   min_nxt = width_r;
      sjcp_pkg::CMD_SET_MAX:   max_nxt = width_r;
      default: begin
        if (is_digit) begin
          width_nxt = digit_q;
        end else begin
          cmd_status_nxt = 1'b1;
        end
      end
    endcase
    high_time_nxt = (width_nxt > pulse_overhead_r) ? width_nxt - pulse_overhead_r : '0;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      width_r          <= sjcp_pkg::DEFAULT_WIDTH_RST;
      min_r            <= sjcp_pkg::MIN_RST;
      max_r            <= sjcp_pkg::MAX_RST;
      default_width_r  <= sjcp_pkg::DEFAULT_WIDTH_RST;
      step_size_r      <= sjcp_pkg::STEP_SIZE_RST;
      pulse_overhead_r <= sjcp_pkg::PULSE_OVERHEAD_RST;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        width_r     <= width_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          sjcp_pkg::REG_DEFAULT_WIDTH:  default_width_r  <= cfg_if.data;
          sjcp_pkg::REG_STEP_SIZE:      step_size_r      <= cfg_if.data;
          sjcp_pkg::REG_PULSE_OVERHEAD: pulse_overhead_r <= cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_if.cmd_byte;
    end
    if (advance) begin
      pulse_width_r <= width_nxt;
      low_limit_r   <= min_nxt;
      high_limit_r  <= max_nxt;
      high_time_r   <= high_time_nxt;
      cmd_status_r  <= cmd_status_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pulse_width = pulse_width_r;
  assign out_if.low_limit   = low_limit_r;
  assign out_if.high_limit  = high_limit_r;
  assign out_if.high_time   = high_time_r;
  assign out_if.cmd_status  = cmd_status_r;

endmodule

### design/sjcp_checker.sv
// sjcp_checker: port-level assertions for the positioner, bound to the top level.
// Depends on sjcp_pkg.
module sjcp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sjcp_pkg::width_t out_pulse_width,
  input sjcp_pkg::width_t out_low_limit,
  input sjcp_pkg::width_t out_high_limit,
  input sjcp_pkg::width_t out_high_time,
  input logic             out_cmd_status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_width) &&
      $stable(out_low_limit) && $stable(out_high_limit) && $stable(out_high_time) &&
      $stable(out_cmd_status))
    else $error("result beat changed while stalled");

  // an accepted command beat is followed by a valid result beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result two cycles after command beat");

  // input only backs up when the output is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("command refused without output stall");

  // high time never exceeds the width
  a_high_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_high_time <= out_pulse_width)
    else $error("high time above pulse width");

endmodule

bind servo_jog_command_positioner sjcp_checker u_sjcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_pulse_width (out_if.pulse_width),
  .out_low_limit   (out_if.low_limit),
  .out_high_limit  (out_if.high_limit),
  .out_high_time   (out_if.high_time),
  .out_cmd_status  (out_if.cmd_status)
);
